// ===== hdl/bsh32_pkg.sv =====
// Shared types and constants for the byte-serial 32-bit string hash.
// This package has no dependencies. All other files in hdl/ use it.
package bsh32_pkg;

    typedef logic [31:0] t_word;
    typedef logic [7:0]  t_byte;

    // Seeds for the running words
    localparam t_word SEED_FIRST  = 32'hdeadbeef;
    localparam t_word SEED_SECOND = 32'h41c6ce57;

    // Per-byte multipliers
    localparam t_word MUL_FIRST  = 32'd2654435761;
    localparam t_word MUL_SECOND = 32'd1597334677;

    // Finalisation multipliers
    localparam t_word FIN_FIRST  = 32'd2246822507;
    localparam t_word FIN_SECOND = 32'd3266489909;

    // Fold shifts used at finalisation
    localparam int FOLD_FIRST  = 16;
    localparam int FOLD_SECOND = 13;

    // Control for the shared multiplier
    typedef struct packed {
        logic  en;
        t_word op_a;
        t_word op_b;
    } t_mul_req;

endpackage

// ===== hdl/bsh32_if.sv =====
// Valid/ready channel interfaces for the string hash: byte input and hash output.
// Depends on bsh32_pkg for the payload types.
interface bsh32_in_if;
    logic               valid;
    logic               ready;
    bsh32_pkg::t_byte   data_byte;
    logic               last_byte;
    logic               empty_end;

    modport source (output valid, output data_byte, output last_byte, output empty_end,
                    input ready);
    modport sink   (input valid, input data_byte, input last_byte, input empty_end,
                    output ready);
endinterface

interface bsh32_out_if;
    logic               valid;
    logic               ready;
    bsh32_pkg::t_word   hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

// ===== hdl/byte_string_hash_32_top.sv =====
// Byte-serial 32-bit string hash: sequencer around one shared multiplier.
// A plain byte is accepted, takes two multiplier passes and a write-back; a final byte
// takes both passes, two finalisation passes and emit; an empty end goes to finalisation.
// The hash then sits in the output register; emit waits on a full output.
// Synchronous active-low reset returns both words to their seeds and drops out valid.
// Depends on bsh32_pkg, bsh32_if and bsh32_mul.
module byte_string_hash_32_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bsh32_in_if.sink    i_in,
    bsh32_out_if.source o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ABS1,
        S_ABS2,
        S_ABSW,
        S_FIN1,
        S_FIN2,
        S_EMIT
    } t_state;

    t_state              r_state;
    bsh32_pkg::t_word    r_first;
    bsh32_pkg::t_word    r_second;
    bsh32_pkg::t_word    r_part;
    bsh32_pkg::t_word    r_hash;
    bsh32_pkg::t_byte    r_byte;
    logic                r_last;
    logic                r_absorb;
    logic                r_out_valid;

    bsh32_pkg::t_mul_req w_req;
    bsh32_pkg::t_word    w_prod;
    bsh32_pkg::t_word    w_byte_ext;
    logic                w_accept;
    logic                w_out_free;

    assign w_byte_ext = {24'd0, r_byte};
    assign w_accept   = i_in.valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || o_out.ready;

    // Operand selection for the shared multiplier
    always_comb begin
        w_req = '0;
        unique case (r_state)
            S_ABS1: begin
                w_req.en   = 1'b1;
                w_req.op_a = r_first ^ w_byte_ext;
                w_req.op_b = bsh32_pkg::MUL_FIRST;
            end
            S_ABS2: begin
                w_req.en   = 1'b1;
                w_req.op_a = r_second ^ w_byte_ext;
                w_req.op_b = bsh32_pkg::MUL_SECOND;
            end
            S_FIN1: begin
                w_req.en   = 1'b1;
                w_req.op_a = r_first ^ (r_first >> bsh32_pkg::FOLD_FIRST);
                w_req.op_b = bsh32_pkg::FIN_FIRST;
            end
            S_FIN2: begin
                w_req.en   = 1'b1;
                w_req.op_a = r_second ^ (r_second >> bsh32_pkg::FOLD_SECOND);
                w_req.op_b = bsh32_pkg::FIN_SECOND;
            end
            default: begin
                w_req = '0;
            end
        endcase
    end

    bsh32_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_req),
        .o_prod (w_prod)
    );

    // Sequencer, running words and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first     <= bsh32_pkg::SEED_FIRST;
            r_second    <= bsh32_pkg::SEED_SECOND;
            r_out_valid <= 1'b0;
            r_absorb    <= 1'b0;
        end else begin
            // new hash loads the output; otherwise a taken hash clears it
            if (r_state == S_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_byte   <= i_in.data_byte;
                        r_last   <= i_in.last_byte;
                        r_absorb <= !i_in.empty_end;
                        r_state  <= i_in.empty_end ? S_FIN1 : S_ABS1;
                    end
                end
                S_ABS1: begin
                    r_state <= S_ABS2;
                end
                S_ABS2: begin
                    r_first <= w_prod;
                    r_state <= r_last ? S_FIN1 : S_ABSW;
                end
                S_ABSW: begin
                    r_second <= w_prod;
                    r_state  <= S_IDLE;
                end
                S_FIN1: begin
                    // second word product from the final byte lands here
                    if (r_absorb) begin
                        r_second <= w_prod;
                    end
                    r_state <= S_FIN2;
                end
                S_FIN2: begin
                    r_part  <= w_prod;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_hash      <= r_part ^ w_prod;
                        r_first     <= bsh32_pkg::SEED_FIRST;
                        r_second    <= bsh32_pkg::SEED_SECOND;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.hash_value = r_hash;

    // A transaction occupies the sequencer: no back-to-back accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while sequencer busy");

    // A new hash only ever comes from the emit step
    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_out_valid) && r_out_valid) |-> ($past(r_state) == S_EMIT))
        else $error("output valid raised outside emit");

    // Words are back at their seeds once a hash is emitted
    a_reseed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_out_free) |=>
        (r_first == bsh32_pkg::SEED_FIRST && r_second == bsh32_pkg::SEED_SECOND))
        else $error("running words not reseeded after emit");

endmodule

// ===== hdl/bsh32_mul.sv =====
// Shared 32x32 multiplier, low 32 bits of the product, registered output.
// Depends on bsh32_pkg for t_word and t_mul_req.
module bsh32_mul (
    input  logic                i_clk,
    input  bsh32_pkg::t_mul_req i_req,
    output bsh32_pkg::t_word    o_prod
);

    bsh32_pkg::t_word r_prod;
    bsh32_pkg::t_word n_prod;

    // Product modulo 2^32
    always_comb begin
        n_prod = bsh32_pkg::t_word'(i_req.op_a * i_req.op_b);
    end

    // Holds its value when not enabled
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== tb/bsh32_hash_checker.sv =====
// Checker for the byte-serial string hash: watches both channels, predicts each hash
// from the accepted bytes and compares it with the hash the block returns.
// Depends on bsh32_pkg for the byte and word types.
module bsh32_hash_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  bsh32_pkg::t_byte i_data_byte,
    input  logic             i_last_byte,
    input  logic             i_empty_end,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  bsh32_pkg::t_word i_hash_value,
    output int               o_fail_count,
    output int               o_pending_count,
    output int               o_hash_count
);

    // Hash constants, kept here independently of the design
    localparam bsh32_pkg::t_word START_A    = 32'hdeadbeef;
    localparam bsh32_pkg::t_word START_B    = 32'h41c6ce57;
    localparam bsh32_pkg::t_word BYTE_MUL_A = 32'd2654435761;
    localparam bsh32_pkg::t_word BYTE_MUL_B = 32'd1597334677;
    localparam bsh32_pkg::t_word FOLD_MUL_A = 32'd2246822507;
    localparam bsh32_pkg::t_word FOLD_MUL_B = 32'd3266489909;

    bsh32_pkg::t_word run_a;
    bsh32_pkg::t_word run_b;
    bsh32_pkg::t_word pending_hashes[$];
    int               fails;
    int               hashes_seen;

    // Fold each running word onto itself, scramble, and combine
    function automatic bsh32_pkg::t_word finalise(input bsh32_pkg::t_word a,
                                                  input bsh32_pkg::t_word b);
        bsh32_pkg::t_word fa;
        bsh32_pkg::t_word fb;
        fa = (a ^ (a >> 16)) * FOLD_MUL_A;
        fb = (b ^ (b >> 13)) * FOLD_MUL_B;
        return fa ^ fb;
    endfunction

    initial begin
        run_a       = START_A;
        run_b       = START_B;
        fails       = 0;
        hashes_seen = 0;
    end

    // Sample both handshakes at each edge; outputs to the top go out by NBA
    always @(posedge i_clk) begin : p_check
        bsh32_pkg::t_word want;
        if (!i_rst_n) begin
            run_a = START_A;
            run_b = START_B;
            pending_hashes.delete();
        end else begin
            // hash transaction: compare against the oldest predicted hash
            if (i_out_valid === 1'b1 && i_out_ready === 1'b1) begin
                hashes_seen++;
                if (pending_hashes.size() == 0) begin
                    fails++;
                    $display("%0t: hash mismatch: expected none, actual %08h",
                             $time, i_hash_value);
                end else begin
                    want = pending_hashes.pop_front();
                    if (i_hash_value !== want) begin
                        fails++;
                        $display("%0t: hash mismatch: expected %08h, actual %08h",
                                 $time, want, i_hash_value);
                    end
                end
            end
            // byte transaction: absorb the byte unless it is a bare end marker
            if (i_in_valid === 1'b1 && i_in_ready === 1'b1) begin
                if (!i_empty_end) begin
                    run_a = (run_a ^ {24'd0, i_data_byte}) * BYTE_MUL_A;
                    run_b = (run_b ^ {24'd0, i_data_byte}) * BYTE_MUL_B;
                end
                if (i_empty_end || i_last_byte) begin
                    pending_hashes.push_back(finalise(run_a, run_b));
                    run_a = START_A;
                    run_b = START_B;
                end
            end
        end
        o_fail_count    <= fails;
        o_pending_count <= pending_hashes.size();
        o_hash_count    <= hashes_seen;
    end

endmodule

// ===== tb/byte_string_hash_32_top_tb.sv =====
// Testbench top for the byte-serial string hash: clock, reset, byte stimulus and
// output back-pressure over several traffic phases, then the verdict.
// Depends on bsh32_pkg, bsh32_if, byte_string_hash_32_top and bsh32_hash_checker.
module byte_string_hash_32_top_tb;

    typedef enum {MODE_FREE, MODE_SRC_IDLE, MODE_SNK_STALL, MODE_BOTH} t_traffic;

    localparam int          PHASE_ITEMS = 250;
    localparam int          HOLD_CYCLES = 300;
    localparam int          DRAIN_WAIT  = 16;
    localparam int unsigned CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    t_traffic    traffic;
    int          stall_requests;
    int          items_sent;
    int          strings_sent;
    int          bytes_sent;
    int unsigned cycle_count;
    int          fail_count;
    int          pending_count;
    int          hash_count;

    bsh32_in_if  in_ch();
    bsh32_out_if out_ch();

    byte_string_hash_32_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    bsh32_hash_checker u_hash_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_ch.valid),
        .i_in_ready      (in_ch.ready),
        .i_data_byte     (in_ch.data_byte),
        .i_last_byte     (in_ch.last_byte),
        .i_empty_end     (in_ch.empty_end),
        .i_out_valid     (out_ch.valid),
        .i_out_ready     (out_ch.ready),
        .i_hash_value    (out_ch.hash_value),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count),
        .o_hash_count    (hash_count)
    );

    // Clock, period 2
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Cycle counter and watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: run timed out with %0d hashes still awaited", $time, pending_count);
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: random stalls by phase, plus long hold-offs on request
    initial begin : p_receiver
        int hold_left;
        int served;
        int stall_pct;
        hold_left = 0;
        served    = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (served != stall_requests) begin
                served++;
                hold_left = HOLD_CYCLES;
            end
            stall_pct = (traffic == MODE_SNK_STALL) ? 62 : (traffic == MODE_BOTH) ? 6 : 0;
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Offer one byte transaction and hold it until accepted
    task automatic send_item(input bsh32_pkg::t_byte b, input logic last,
                             input logic ends_empty);
        int gap;
        int idle_pct;
        gap      = 0;
        idle_pct = (traffic == MODE_SRC_IDLE) ? 62 : (traffic == MODE_BOTH) ? 6 : 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last_byte <= last;
        in_ch.empty_end <= ends_empty;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        items_sent++;
        if (ends_empty || last) strings_sent++;
        if (!ends_empty) bytes_sent++;
    endtask

    // Drop valid and wait until every predicted hash has come back
    task automatic drain_hashes();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    // One string of random length and content, ended by a final byte or an end marker
    task automatic send_random_string();
        int len;
        int pick;
        bit marker_end;
        pick = $urandom_range(99);
        if (pick < 10) len = 0;
        else if (pick < 90) len = $urandom_range(12, 1);
        else len = $urandom_range(48, 13);
        marker_end = (len == 0) || ($urandom_range(99) < 30);
        for (int i = 0; i < len; i++) begin
            send_item(bsh32_pkg::t_byte'($urandom_range(255)),
                      !marker_end && (i == len - 1), 1'b0);
        end
        // ignored fields of the end marker still carry random values
        if (marker_end) send_item(bsh32_pkg::t_byte'($urandom_range(255)),
                                  1'($urandom_range(1)), 1'b1);
    endtask

    initial begin : p_stimulus
        int phase_end;
        traffic        = MODE_FREE;
        stall_requests = 0;
        items_sent     = 0;
        strings_sent   = 0;
        bytes_sent     = 0;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= '0;
        in_ch.last_byte <= 1'b0;
        in_ch.empty_end <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty string, also with its ignored fields at their highs
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        // Single-byte strings at the byte extremes
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        // Zero bytes inside a string do not end it
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        // String closed by an end marker after some bytes, then a two-byte string
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h80, 1'b0, 1'b0);
        send_item(8'h01, 1'b0, 1'b0);
        send_item(8'ha5, 1'b1, 1'b1);
        send_item(8'h7f, 1'b0, 1'b0);
        send_item(8'hfe, 1'b1, 1'b0);

        // Random strings, one phase per traffic pattern
        for (int m = 0; m < 4; m++) begin
            traffic   = t_traffic'(m);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                send_random_string();
                // long output hold-off while bytes keep coming
                if (traffic == MODE_FREE && stall_requests == 0 && items_sent > phase_end - 200)
                    stall_requests++;
            end
            // sender pauses until all hashes are home after the first phase
            if (m == 0) drain_hashes();
        end

        drain_hashes();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("Sent %0d transactions: %0d strings, %0d bytes, over four traffic phases",
                 items_sent, strings_sent, bytes_sent);
        $display("Compared %0d hashes, including a %0d-cycle output hold-off",
                 hash_count, HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
